// File: rtl/prwl_pkg.sv
// Shared types, constants and codes for the priority request wait list.
`default_nettype none
package prwl_pkg;

    localparam int SLOTS = 16;
    localparam int IW    = $clog2(SLOTS);

    // slot status
    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // priorities
    localparam logic [2:0] PR_MIDLOW  = 3'd1;
    localparam logic [2:0] PR_MID     = 3'd2;
    localparam logic [2:0] PR_MIDHIGH = 3'd3;
    localparam logic [2:0] PR_HIGH    = 3'd4;

    // actions
    localparam logic [1:0] ACT_ENQ    = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_FIND   = 2'd3;

    // result codes
    localparam logic [2:0] RES_OK       = 3'd0;
    localparam logic [2:0] RES_NOREPLY  = 3'd1;
    localparam logic [2:0] RES_BACKWAIT = 3'd2;
    localparam logic [2:0] RES_CONT     = 3'd3;
    localparam logic [2:0] RES_STILL    = 3'd4;

    // status codes
    localparam logic [2:0] SC_OK       = 3'd0;
    localparam logic [2:0] SC_INVALID  = 3'd1;
    localparam logic [2:0] SC_FULL     = 3'd2;
    localparam logic [2:0] SC_NOREPLY  = 3'd3;
    localparam logic [2:0] SC_PASSED   = 3'd4;
    localparam logic [2:0] SC_NOTFOUND = 3'd5;

    // config register indexes
    localparam logic [2:0] CFG_MIDLOW_A = 3'd0;
    localparam logic [2:0] CFG_MIDLOW_B = 3'd1;
    localparam logic [2:0] CFG_MIDLOW_C = 3'd2;
    localparam logic [2:0] CFG_HIGH     = 3'd3;
    localparam logic [2:0] CFG_MIDHIGH  = 3'd4;
    localparam logic [2:0] CFG_SHORTCAP = 3'd5;

    // cell operations
    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_SHIFT = 2'd1;
    localparam logic [1:0] CELL_CLEAR = 2'd2;
    localparam logic [1:0] CELL_SORT  = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  prio;
        logic [15:0] func;
        logic [31:0] payload;
    } t_entry;

    typedef struct packed {
        logic [1:0] op;
        logic       phase;
    } t_cell_ctl;

endpackage
`default_nettype wire

// File: rtl/prwl_cell.sv
// One slot cell: holds an entry, shifts, clears finished, or compare-swaps with a neighbor.
`default_nettype none
module prwl_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  prwl_pkg::t_cell_ctl i_ctl,
    input  wire                 i_odd,
    input  prwl_pkg::t_entry    i_shift_in,
    input  prwl_pkg::t_entry    i_left,
    input  prwl_pkg::t_entry    i_right,
    output prwl_pkg::t_entry    o_entry
);

    prwl_pkg::t_entry r_entry;
    prwl_pkg::t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            prwl_pkg::CELL_SHIFT: n_entry = i_shift_in;
            prwl_pkg::CELL_CLEAR: begin
                if (r_entry.status == prwl_pkg::ST_FIN) begin
                    n_entry = '0;
                end
            end
            prwl_pkg::CELL_SORT: begin
                // strict compare keeps equal priorities in order
                if (i_odd == i_ctl.phase) begin
                    if (r_entry.prio < i_right.prio) begin
                        n_entry = i_right;
                    end
                end else begin
                    if (i_left.prio < r_entry.prio) begin
                        n_entry = i_left;
                    end
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

// File: rtl/priority_request_wait_list.sv
// Top level: request slot table built as a ring of cells with a scan sequencer.
//
// channel | direction | handshake            | content
// s_      | in        | s_tvalid / s_tready  | request: tuser action, tdata fields
// m_      | out       | m_tvalid / m_tready  | result: status, slot, error
// cfg     | in        | i_cfg_valid / o_cfg_ready | register index and value
//
// Enqueue, update and find rotate the ring once past the head cell before the result
// is registered. Remove clears finished slots, then sorts them by odd-even transposition.
// One request is in work at a time.
// Synchronous active-low reset empties every slot and sets the config registers and sequencer to reset values.
// A result waiting on m_tready holds the sequencer at its end; a new request can be
// taken while the previous result still waits.
`default_nettype none
module priority_request_wait_list (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [15:0] func_id, [47:16] payload_tag, [63:48] data_size, [64] long_data,
    // [68:65] slot_index, [71:69] result_code
    input  wire  [71:0] s_tdata,
    // [1:0] action
    input  wire  [1:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [2:0] status_code, [6:3] slot_out, [9:7] error_code, [15:10] zero
    output logic [15:0] m_tdata,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);

    localparam int N  = prwl_pkg::SLOTS;
    localparam int IW = prwl_pkg::IW;
    localparam int WW = (IW > 4) ? IW : 4;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR  = 3'd1;
    localparam logic [2:0] S_ROT  = 3'd2;
    localparam logic [2:0] S_SORT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [15:0] r_ml_a, r_ml_b, r_ml_c, r_high, r_mh, r_cap;

    logic [2:0]    r_state;
    logic [IW-1:0] r_cnt;
    logic [1:0]    r_act;
    logic [15:0]   r_fid;
    logic [31:0]   r_tag;
    logic          r_size_ok;
    logic [2:0]    r_prio;
    logic [3:0]    r_idx;
    logic [2:0]    r_res;
    logic          r_found;
    logic [3:0]    r_slot;
    logic [2:0]    r_st;
    logic [2:0]    r_err;

    prwl_pkg::t_entry    w_entry [N];
    prwl_pkg::t_entry    w_head;
    prwl_pkg::t_cell_ctl w_ctl;

    logic [15:0] w_fid;
    logic [15:0] w_size;
    logic [2:0]  w_prio;
    logic        w_s_acc;
    logic        w_out_free;
    logic [3:0]  w_cnt4;
    logic [WW-1:0] w_cnt_w;
    logic [WW-1:0] w_idx_w;

    assign w_fid   = s_tdata[15:0];
    assign w_size  = s_tdata[63:48];
    assign s_tready = (r_state == S_IDLE);
    assign w_s_acc = s_tvalid && s_tready;
    assign o_cfg_ready = 1'b1;
    assign w_out_free = !m_tvalid || m_tready;
    assign w_cnt_w = WW'(r_cnt);
    assign w_idx_w = WW'(r_idx);
    assign w_cnt4  = w_cnt_w[3:0];

    always_comb begin
        if (w_fid == r_ml_a || w_fid == r_ml_b || w_fid == r_ml_c) begin
            w_prio = prwl_pkg::PR_MIDLOW;
        end else if (w_fid == r_high) begin
            w_prio = prwl_pkg::PR_HIGH;
        end else if (w_fid == r_mh) begin
            w_prio = prwl_pkg::PR_MIDHIGH;
        end else begin
            w_prio = prwl_pkg::PR_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ml_a <= '0;
            r_ml_b <= '0;
            r_ml_c <= '0;
            r_high <= '0;
            r_mh   <= '0;
            r_cap  <= 16'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                prwl_pkg::CFG_MIDLOW_A: r_ml_a <= i_cfg_data;
                prwl_pkg::CFG_MIDLOW_B: r_ml_b <= i_cfg_data;
                prwl_pkg::CFG_MIDLOW_C: r_ml_c <= i_cfg_data;
                prwl_pkg::CFG_HIGH:     r_high <= i_cfg_data;
                prwl_pkg::CFG_MIDHIGH:  r_mh   <= i_cfg_data;
                prwl_pkg::CFG_SHORTCAP: r_cap  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // cell control
    always_comb begin
        w_ctl.phase = r_cnt[0];
        case (r_state)
            S_CLR:   w_ctl.op = prwl_pkg::CELL_CLEAR;
            S_ROT:   w_ctl.op = prwl_pkg::CELL_SHIFT;
            S_SORT:  w_ctl.op = prwl_pkg::CELL_SORT;
            default: w_ctl.op = prwl_pkg::CELL_HOLD;
        endcase
    end

    // head cell is edited on its way back to the tail
    always_comb begin
        w_head = w_entry[0];
        case (r_act)
            prwl_pkg::ACT_ENQ: begin
                if (!r_found && w_entry[0].status == prwl_pkg::ST_NONE && r_size_ok) begin
                    w_head.status  = prwl_pkg::ST_WAIT;
                    w_head.prio    = r_prio;
                    w_head.func    = r_fid;
                    w_head.payload = r_tag;
                end
            end
            prwl_pkg::ACT_UPDATE: begin
                if (w_cnt_w == w_idx_w && w_entry[0].status != prwl_pkg::ST_NONE) begin
                    case (r_res)
                        prwl_pkg::RES_BACKWAIT, prwl_pkg::RES_STILL:
                            w_head.status = prwl_pkg::ST_WAIT;
                        prwl_pkg::RES_CONT:
                            w_head.status = prwl_pkg::ST_RUN;
                        default:
                            w_head.status = prwl_pkg::ST_FIN;
                    endcase
                end
            end
            default: ;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            prwl_pkg::t_entry w_sin, w_l, w_r;
            if (g == N - 1) begin : g_tail
                assign w_sin = w_head;
                assign w_r   = '0;
            end else begin : g_mid
                assign w_sin = w_entry[g+1];
                assign w_r   = w_entry[g+1];
            end
            if (g == 0) begin : g_first
                // unpaired in odd rounds: comparing against itself never swaps
                assign w_l = w_entry[0];
            end else begin : g_rest
                assign w_l = w_entry[g-1];
            end
            prwl_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_odd      (1'(g % 2)),
                .i_shift_in (w_sin),
                .i_left     (w_l),
                .i_right    (w_r),
                .o_entry    (w_entry[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            m_tvalid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        r_cnt   <= '0;
                        r_state <= (s_tuser == prwl_pkg::ACT_REMOVE) ? S_CLR : S_ROT;
                    end
                end
                S_CLR: r_state <= S_SORT;
                S_ROT, S_SORT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == IW'(N - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_act     <= s_tuser;
            r_fid     <= w_fid;
            r_tag     <= s_tdata[47:16];
            r_size_ok <= s_tdata[64] || (w_size <= r_cap);
            r_prio    <= w_prio;
            r_idx     <= s_tdata[68:65];
            r_res     <= s_tdata[71:69];
            r_found   <= 1'b0;
            r_slot    <= '0;
            r_st      <= prwl_pkg::SC_OK;
            r_err     <= '0;
        end else if (r_state == S_ROT) begin
            case (r_act)
                prwl_pkg::ACT_ENQ: begin
                    if (!r_found && w_entry[0].status == prwl_pkg::ST_NONE) begin
                        r_found <= 1'b1;
                        r_slot  <= w_cnt4;
                    end
                end
                prwl_pkg::ACT_UPDATE: begin
                    r_slot <= r_idx;
                    if (w_cnt_w == w_idx_w && w_entry[0].status != prwl_pkg::ST_NONE) begin
                        if (r_res == prwl_pkg::RES_NOREPLY) begin
                            r_st <= prwl_pkg::SC_NOREPLY;
                        end else if (r_res > prwl_pkg::RES_STILL) begin
                            r_st  <= prwl_pkg::SC_PASSED;
                            r_err <= r_res;
                        end
                    end
                end
                prwl_pkg::ACT_FIND: begin
                    if (!r_found && w_entry[0].func == r_fid) begin
                        r_found <= 1'b1;
                        r_slot  <= w_cnt4;
                    end
                end
                default: ;
            endcase
        end
    end

    // final status, formed when the result is loaded
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            case (r_act)
                prwl_pkg::ACT_ENQ: begin
                    if (!r_found) begin
                        m_tdata <= {13'd0, prwl_pkg::SC_FULL};
                    end else if (!r_size_ok) begin
                        m_tdata <= {13'd0, prwl_pkg::SC_INVALID};
                    end else begin
                        m_tdata <= {9'd0, r_slot, prwl_pkg::SC_OK};
                    end
                end
                prwl_pkg::ACT_UPDATE: begin
                    m_tdata <= {6'd0, r_err, r_slot, r_st};
                end
                prwl_pkg::ACT_FIND: begin
                    if (r_found) begin
                        m_tdata <= {9'd0, r_slot, prwl_pkg::SC_OK};
                    end else begin
                        m_tdata <= {13'd0, prwl_pkg::SC_NOTFOUND};
                    end
                end
                default: m_tdata <= '0;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another in work");

    a_load_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(r_state) == S_DONE)
        else $error("result loaded outside end of sequence");

    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_act == prwl_pkg::ACT_REMOVE) |->
        w_entry[0].prio >= w_entry[1].prio)
        else $error("slots not in priority order after remove");
`endif

endmodule
`default_nettype wire

// File: tb/sv/tb_priority_request_wait_list.sv
// Self-checking testbench for the priority request wait list block.
`timescale 1ns / 100ps
`default_nettype none
module tb_priority_request_wait_list;
    import prwl_pkg::*;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] slot;
        logic [2:0] err;
    } t_reply;

    // Scoreboard: a table model that predicts each reply and keeps them in order.
    class slot_table_sb;
        t_entry      tab[SLOTS];
        logic [15:0] cfg[6];
        t_reply      pending[$];
        int          errors;

        function new();
            foreach (tab[i]) tab[i] = '0;
            foreach (cfg[i]) cfg[i] = 16'd0;
            cfg[CFG_SHORTCAP] = 16'd256;
            errors = 0;
        endfunction

        function logic [2:0] rank(logic [15:0] id);
            if (id == cfg[CFG_MIDLOW_A] || id == cfg[CFG_MIDLOW_B] || id == cfg[CFG_MIDLOW_C])
                return PR_MIDLOW;
            if (id == cfg[CFG_HIGH]) return PR_HIGH;
            if (id == cfg[CFG_MIDHIGH]) return PR_MIDHIGH;
            return PR_MID;
        endfunction

        function void note_request(logic [1:0] act, logic [71:0] d);
            t_reply      r;
            logic [15:0] fid;
            int          k;
            int          free_slot;
            t_entry      packed_tab[SLOTS];
            fid = d[15:0];
            r = '0;
            case (act)
                ACT_ENQ: begin
                    free_slot = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (free_slot < 0 && tab[i].status == ST_NONE) free_slot = i;
                    if (free_slot < 0) r.status = SC_FULL;
                    else if (!d[64] && d[63:48] > cfg[CFG_SHORTCAP]) r.status = SC_INVALID;
                    else begin
                        tab[free_slot] = '{ST_WAIT, rank(fid), fid, d[47:16]};
                        r.slot = 4'(free_slot);
                    end
                end
                ACT_UPDATE: begin
                    k = d[68:65];
                    r.slot = d[68:65];
                    if (tab[k].status != ST_NONE) begin
                        case (d[71:69])
                            RES_OK:       tab[k].status = ST_FIN;
                            RES_NOREPLY:  begin tab[k].status = ST_FIN; r.status = SC_NOREPLY; end
                            RES_BACKWAIT: tab[k].status = ST_WAIT;
                            RES_CONT:     tab[k].status = ST_RUN;
                            RES_STILL:    tab[k].status = ST_WAIT;
                            default: begin
                                tab[k].status = ST_FIN;
                                r.status = SC_PASSED;
                                r.err = d[71:69];
                            end
                        endcase
                    end
                end
                ACT_REMOVE: begin
                    k = 0;
                    foreach (packed_tab[i]) packed_tab[i] = '0;
                    for (int p = PR_HIGH; p >= PR_MIDLOW; p--)
                        for (int i = 0; i < SLOTS; i++)
                            if ((tab[i].status == ST_WAIT || tab[i].status == ST_RUN)
                                && tab[i].prio == p) begin
                                packed_tab[k] = tab[i];
                                k++;
                            end
                    tab = packed_tab;
                end
                default: begin
                    r.status = SC_NOTFOUND;
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (tab[i].func == fid) begin
                            r.status = SC_OK;
                            r.slot = 4'(i);
                        end
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_reply(logic [15:0] got);
            t_reply want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected reply %h", $realtime, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got[2:0] !== want.status)
                $display("%0t: status exp %0d got %0d", $realtime, want.status, got[2:0]);
            if (got[6:3] !== want.slot)
                $display("%0t: slot exp %0d got %0d", $realtime, want.slot, got[6:3]);
            if (got[9:7] !== want.err)
                $display("%0t: error exp %0d got %0d", $realtime, want.err, got[9:7]);
            if (got[15:10] !== 6'd0)
                $display("%0t: pad exp 0 got %h", $realtime, got[15:10]);
            if (got[2:0] !== want.status || got[6:3] !== want.slot || got[9:7] !== want.err
                || got[15:10] !== 6'd0)
                errors++;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    slot_table_sb sb;
    int           idle_cycles;
    logic         sink_hold;
    logic         stim_done;

    priority_request_wait_list u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // a few ids reused so priorities and find hits actually happen
    function logic [15:0] pick_id();
        case ($urandom_range(0, 3))
            0: return sb.cfg[$urandom_range(0, 4)];
            1: return 16'($urandom_range(0, 7));
            2: return 16'($urandom);
            default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    task automatic send_request(logic [1:0] act, logic [71:0] d);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= d;
        do @(posedge i_clk); while (!s_tready);
        sb.note_request(act, d);
        // burst with random gaps
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_op(logic [1:0] act, logic [15:0] fid, logic [15:0] sz, logic lng,
                           logic [3:0] idx, logic [2:0] res);
        send_request(act, {res, idx, lng, sz, 32'($urandom), fid});
    endtask

    task automatic send_random();
        logic [71:0] d;
        logic [1:0]  act;
        d = 72'({$urandom, $urandom, $urandom});
        d[15:0] = pick_id();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: act = ACT_ENQ;
            4, 5, 6:    act = ACT_UPDATE;
            7:          act = ACT_REMOVE;
            default:    act = ACT_FIND;
        endcase
        if (act == ACT_ENQ && $urandom_range(0, 3) != 0)
            d[63:48] = 16'($urandom_range(0, 300));
        send_request(act, d);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (3 * SLOTS) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.cfg[idx] = val;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                             logic [15:0] h, logic [15:0] mh, logic [15:0] cap);
        write_reg(CFG_MIDLOW_A, a);
        write_reg(CFG_MIDLOW_B, b);
        write_reg(CFG_MIDLOW_C, c);
        write_reg(CFG_HIGH, h);
        write_reg(CFG_MIDHIGH, mh);
        write_reg(CFG_SHORTCAP, cap);
        @(posedge i_clk);
    endtask

    // receiver: random stalls, a forced hold-off while sink_hold is set, always-ready once stimulus is done
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold) m_tready <= 1'b0;
            else if ($urandom_range(0, 7) < 2 && !stim_done) m_tready <= 1'b0;
            else m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_reply(m_tdata);
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= 20000);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        sb = new();
        idle_cycles = 0;
        sink_hold = 1'b0;
        stim_done = 1'b0;
        i_rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= ACT_ENQ;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_MIDLOW_A;
        i_cfg_data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config, id 0 matches mid-low, full table, size limits, every result code, remove
        send_op(ACT_FIND, 16'h1234, 16'd0, 1'b0, 4'd0, RES_OK);
        send_op(ACT_UPDATE, 16'd0, 16'd0, 1'b0, 4'd15, RES_OK);
        send_op(ACT_ENQ, 16'h0000, 16'd256, 1'b0, 4'd0, RES_OK);
        send_op(ACT_ENQ, 16'hFFFF, 16'd257, 1'b0, 4'd0, RES_OK);
        send_op(ACT_ENQ, 16'hFFFF, 16'hFFFF, 1'b1, 4'd0, RES_OK);
        for (int i = 0; i < SLOTS; i++)
            send_op(ACT_ENQ, 16'(i), 16'd0, 1'b0, 4'd0, RES_OK);
        send_op(ACT_FIND, 16'hFFFF, 16'd0, 1'b0, 4'd0, RES_OK);
        for (int r = 0; r < 8; r++)
            send_op(ACT_UPDATE, 16'd0, 16'd0, 1'b0, 4'(r * 2), 3'(r));
        send_op(ACT_REMOVE, 16'd0, 16'd0, 1'b0, 4'd0, RES_OK);
        send_op(ACT_FIND, 16'h0000, 16'd0, 1'b0, 4'd0, RES_OK);
        drain();

        // random phases over several register settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_all(16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd100);
                1: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                3: write_all(16'd6, 16'd7, 16'hFFFF, 16'd1, 16'd2, 16'd200);
                default: write_all(16'($urandom), 16'($urandom_range(0, 7)),
                                   16'($urandom_range(0, 7)), 16'($urandom_range(0, 7)),
                                   16'($urandom_range(0, 7)), 16'($urandom_range(0, 300)));
            endcase
            if (ph == 2) begin
                // long receiver hold-off while requests keep coming
                fork
                    begin
                        sink_hold = 1'b1;
                        repeat (400) @(posedge i_clk);
                        sink_hold = 1'b0;
                    end
                    repeat (325) send_random();
                join
            end else
                repeat (325) send_random();
            drain();
        end

        stim_done = 1'b1;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
rtl/prwl_pkg.sv
rtl/prwl_cell.sv
rtl/priority_request_wait_list.sv
tb/sv/tb_priority_request_wait_list.sv
